// ===== sv/tmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// tmhq_pkg
// Shared types and constants of the timer min-heap queue: sizes, command and
// status codes, item and heap entry structures, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tmhq_pkg;

    // sizes
    localparam int CAPACITY    = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int CHILD_W     = IDX_W + 2;
    localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

    // command codes
    localparam logic [1:0] CMD_ADD     = 2'd0;
    localparam logic [1:0] CMD_CANCEL  = 2'd1;
    localparam logic [1:0] CMD_SERVICE = 2'd2;

    // status codes
    localparam logic [2:0] STS_ADDED     = 3'd0;
    localparam logic [2:0] STS_FULL      = 3'd1;
    localparam logic [2:0] STS_FOUND     = 3'd2;
    localparam logic [2:0] STS_NOT_FOUND = 3'd3;
    localparam logic [2:0] STS_FIRED     = 3'd4;
    localparam logic [2:0] STS_NONE      = 3'd5;

    // input item
    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] expire_time;
        logic [31:0] cancel_id;
        logic [63:0] now_time;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] timer_ident;
        logic        last;
    } t_out_item;

    // one heap slot
    typedef struct packed {
        logic [63:0] expiry;
        logic [31:0] ident;
        logic        cancelled;
    } t_entry;

    // slot store write port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_wr_port;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_UP,
        ST_CANCEL,
        ST_SV_CHECK,
        ST_SV_LAST,
        ST_SD_LEFT,
        ST_SD_RIGHT,
        ST_RESULT
    } t_state;

endpackage

`default_nettype wire

// ===== sv/tmhq_slot_store.sv =====
// ----------------------------------------------------------------------------
// tmhq_slot_store
// Heap slot registers: one write and one selected read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tmhq_slot_store (
    input  wire                               i_clk,
    input  tmhq_pkg::t_wr_port                i_wr,
    input  wire logic [tmhq_pkg::IDX_W-1:0]   i_rd_addr,
    output tmhq_pkg::t_entry                  o_rd_data
);

    tmhq_pkg::t_entry r_slot [tmhq_pkg::CAPACITY];

    // slot write, contents undefined until written
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_slot[i_wr.addr] <= i_wr.data;
        end
    end

    // selected read
    assign o_rd_data = r_slot[i_rd_addr];

endmodule

`default_nettype wire

// ===== sv/tmhq_out_reg.sv =====
// ----------------------------------------------------------------------------
// tmhq_out_reg
// Result output register: holds one item until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tmhq_out_reg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  tmhq_pkg::t_out_item  i_push_item,
    output logic                 o_free,
    output logic                 o_valid,
    input  wire                  i_stall,
    output tmhq_pkg::t_out_item  o_item
);

    logic                r_valid;
    tmhq_pkg::t_out_item r_item;

    // register is free when empty or being taken this cycle
    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_item <= i_push_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/timer_min_heap_queue_core.sv =====
// Timing: add climbs from the new slot towards the root, cancel scans the entries
// in order, service tests the root and sifts the last entry down after each pop; a stalled
// receiver holds the queue whenever a result is waiting to be pushed.
// Throughput: one item at a time; the input stalls until the item's last result is
// pushed, and the next item is taken once the queue is idle again.
// Reset: synchronous, empty heap, identifiers restart at 1; slot contents are
// ----------------------------------------------------------------------------
// timer_min_heap_queue_core
// Timer queue as a binary min-heap on expiry time, with add, cancel by id and
// service of expired timers, sifted one slot access per cycle. Slot contents
// are left as they are at reset and no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_min_heap_queue_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  tmhq_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  wire                  i_stall,
    output tmhq_pkg::t_out_item  o_item
);

    localparam int IDX_W   = tmhq_pkg::IDX_W;
    localparam int CNT_W   = tmhq_pkg::CNT_W;
    localparam int CHILD_W = tmhq_pkg::CHILD_W;
    localparam int FIRE_W  = tmhq_pkg::FIRE_W;

    // control registers
    tmhq_pkg::t_state    r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [31:0]         r_last_ident, n_last_ident;
    logic                r_pend_valid, n_pend_valid;
    logic [FIRE_W-1:0]   r_nfire, n_nfire;

    // payload registers
    logic [IDX_W-1:0]    r_pos, n_pos;
    logic [IDX_W-1:0]    r_best_pos, n_best_pos;
    logic [CNT_W-1:0]    r_idx, n_idx;
    tmhq_pkg::t_entry    r_item, n_item;
    tmhq_pkg::t_entry    r_best, n_best;
    logic [63:0]         r_now, n_now;
    logic [31:0]         r_cancel_id, n_cancel_id;
    logic [31:0]         r_pend_id, n_pend_id;
    tmhq_pkg::t_out_item r_res, n_res;

    // store and output stage links
    tmhq_pkg::t_wr_port  w_wr;
    logic [IDX_W-1:0]    w_rd_addr;
    tmhq_pkg::t_entry    w_rd;
    logic                w_push;
    tmhq_pkg::t_out_item w_push_item;
    logic                w_out_free;

    // shared conditions
    logic                w_accept;
    logic [IDX_W-1:0]    w_pos_m1;
    logic [IDX_W-1:0]    w_parent;
    logic [CHILD_W-1:0]  w_lc;
    logic [CHILD_W-1:0]  w_rc;
    logic                w_lc_in;
    logic                w_rc_in;
    logic                w_up_stop;
    logic                w_full;
    logic                w_scan_end;
    logic                w_match;
    logic                w_fire;
    logic                w_sv_hold;
    logic [CNT_W-1:0]    w_count_m1;
    logic                w_rc_take;
    logic [IDX_W-1:0]    w_tgt_pos;
    tmhq_pkg::t_entry    w_tgt;

    tmhq_slot_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd)
    );

    tmhq_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .o_free      (w_out_free),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item)
    );

    // input handshake
    assign o_stall  = (r_state != tmhq_pkg::ST_IDLE);
    assign w_accept = i_valid && !o_stall;

    // heap index arithmetic
    assign w_pos_m1 = r_pos - 1'b1;
    assign w_parent = w_pos_m1 >> 1;
    assign w_lc     = {1'b0, r_pos, 1'b1};
    assign w_rc     = w_lc + 1'b1;
    assign w_lc_in  = (w_lc < CHILD_W'(r_count));
    assign w_rc_in  = (w_rc < CHILD_W'(r_count));

    // sift-up stops at the root or when the parent is not later
    assign w_up_stop = (r_pos == '0) || (w_rd.expiry <= r_item.expiry);

    // add and cancel tests
    assign w_full     = (r_count >= CNT_W'(tmhq_pkg::CAPACITY));
    assign w_scan_end = (r_idx >= r_count);
    assign w_match    = (w_rd.ident == r_cancel_id);

    // service: root expired and result budget left
    assign w_fire = (r_count != '0) && (r_nfire != FIRE_W'(tmhq_pkg::MAX_RESULTS))
                    && (w_rd.expiry <= r_now);
    assign w_sv_hold  = w_fire && !w_rd.cancelled && r_pend_valid && !w_out_free;
    assign w_count_m1 = r_count - 1'b1;

    // sift-down right child choice
    assign w_rc_take = w_rc_in && (w_rd.expiry < r_best.expiry);
    assign w_tgt_pos = w_rc_take ? w_rc[IDX_W-1:0] : r_best_pos;
    assign w_tgt     = w_rc_take ? w_rd : r_best;

    // slot read address
    always_comb begin
        case (r_state)
            tmhq_pkg::ST_ADD_UP:   w_rd_addr = w_parent;
            tmhq_pkg::ST_CANCEL:   w_rd_addr = r_idx[IDX_W-1:0];
            tmhq_pkg::ST_SV_LAST:  w_rd_addr = r_count[IDX_W-1:0];
            tmhq_pkg::ST_SD_LEFT:  w_rd_addr = w_lc[IDX_W-1:0];
            tmhq_pkg::ST_SD_RIGHT: w_rd_addr = w_rc[IDX_W-1:0];
            default:               w_rd_addr = '0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tmhq_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_item.cmd)
                        tmhq_pkg::CMD_ADD:
                            n_state = w_full ? tmhq_pkg::ST_RESULT : tmhq_pkg::ST_ADD_UP;
                        tmhq_pkg::CMD_CANCEL:  n_state = tmhq_pkg::ST_CANCEL;
                        tmhq_pkg::CMD_SERVICE: n_state = tmhq_pkg::ST_SV_CHECK;
                        default:               n_state = tmhq_pkg::ST_IDLE;
                    endcase
                end
            end
            tmhq_pkg::ST_ADD_UP: begin
                if (w_up_stop) begin
                    n_state = tmhq_pkg::ST_RESULT;
                end
            end
            tmhq_pkg::ST_CANCEL: begin
                if (w_scan_end || w_match) begin
                    n_state = tmhq_pkg::ST_RESULT;
                end
            end
            tmhq_pkg::ST_SV_CHECK: begin
                if (!w_fire) begin
                    n_state = tmhq_pkg::ST_RESULT;
                end else if (!w_sv_hold && (w_count_m1 != '0)) begin
                    n_state = tmhq_pkg::ST_SV_LAST;
                end
            end
            tmhq_pkg::ST_SV_LAST: n_state = tmhq_pkg::ST_SD_LEFT;
            tmhq_pkg::ST_SD_LEFT: begin
                n_state = w_lc_in ? tmhq_pkg::ST_SD_RIGHT : tmhq_pkg::ST_SV_CHECK;
            end
            tmhq_pkg::ST_SD_RIGHT: begin
                n_state = (w_tgt_pos == r_pos) ? tmhq_pkg::ST_SV_CHECK
                                               : tmhq_pkg::ST_SD_LEFT;
            end
            tmhq_pkg::ST_RESULT: begin
                if (w_out_free) begin
                    n_state = tmhq_pkg::ST_IDLE;
                end
            end
            default: n_state = tmhq_pkg::ST_IDLE;
        endcase
    end

    // datapath, slot writes and result pushes
    always_comb begin
        n_count      = r_count;
        n_last_ident = r_last_ident;
        n_pend_valid = r_pend_valid;
        n_nfire      = r_nfire;
        n_pos        = r_pos;
        n_best_pos   = r_best_pos;
        n_idx        = r_idx;
        n_item       = r_item;
        n_best       = r_best;
        n_now        = r_now;
        n_cancel_id  = r_cancel_id;
        n_pend_id    = r_pend_id;
        n_res        = r_res;
        w_wr         = '0;
        w_push       = 1'b0;
        w_push_item  = r_res;
        case (r_state)
            tmhq_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_item.cmd)
                        tmhq_pkg::CMD_ADD: begin
                            if (w_full) begin
                                n_res = '{status: tmhq_pkg::STS_FULL, timer_ident: '0,
                                          last: 1'b1};
                            end else begin
                                n_last_ident = r_last_ident + 1'b1;
                                n_res  = '{status: tmhq_pkg::STS_ADDED,
                                           timer_ident: r_last_ident + 1'b1, last: 1'b1};
                                n_item = '{expiry: i_item.expire_time,
                                           ident: r_last_ident + 1'b1, cancelled: 1'b0};
                                n_pos   = r_count[IDX_W-1:0];
                                n_count = r_count + 1'b1;
                            end
                        end
                        tmhq_pkg::CMD_CANCEL: begin
                            n_cancel_id = i_item.cancel_id;
                            n_idx       = '0;
                        end
                        tmhq_pkg::CMD_SERVICE: begin
                            n_now        = i_item.now_time;
                            n_nfire      = '0;
                            n_pend_valid = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            // climb: move the parent down or settle the new entry
            tmhq_pkg::ST_ADD_UP: begin
                w_wr.en   = 1'b1;
                w_wr.addr = r_pos;
                if (w_up_stop) begin
                    w_wr.data = r_item;
                end else begin
                    w_wr.data = w_rd;
                    n_pos     = w_parent;
                end
            end
            // linear scan for the identifier
            tmhq_pkg::ST_CANCEL: begin
                if (w_scan_end) begin
                    n_res = '{status: tmhq_pkg::STS_NOT_FOUND, timer_ident: '0,
                              last: 1'b1};
                end else if (w_match) begin
                    w_wr.en             = 1'b1;
                    w_wr.addr           = r_idx[IDX_W-1:0];
                    w_wr.data           = w_rd;
                    w_wr.data.cancelled = 1'b1;
                    n_res = '{status: tmhq_pkg::STS_FOUND, timer_ident: '0, last: 1'b1};
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            // root test and pop; fired id waits until the next one is known
            tmhq_pkg::ST_SV_CHECK: begin
                if (!w_fire) begin
                    if (r_pend_valid) begin
                        n_res = '{status: tmhq_pkg::STS_FIRED, timer_ident: r_pend_id,
                                  last: 1'b1};
                    end else begin
                        n_res = '{status: tmhq_pkg::STS_NONE, timer_ident: '0,
                                  last: 1'b1};
                    end
                end else if (!w_sv_hold) begin
                    if (!w_rd.cancelled) begin
                        if (r_pend_valid) begin
                            w_push      = 1'b1;
                            w_push_item = '{status: tmhq_pkg::STS_FIRED,
                                            timer_ident: r_pend_id, last: 1'b0};
                        end
                        n_pend_valid = 1'b1;
                        n_pend_id    = w_rd.ident;
                        n_nfire      = r_nfire + 1'b1;
                    end
                    n_count = w_count_m1;
                end
            end
            // take the last entry as the one to sift down from the root
            tmhq_pkg::ST_SV_LAST: begin
                n_item = w_rd;
                n_pos  = '0;
            end
            // left child against the moving entry
            tmhq_pkg::ST_SD_LEFT: begin
                if (!w_lc_in) begin
                    w_wr.en   = 1'b1;
                    w_wr.addr = r_pos;
                    w_wr.data = r_item;
                end else if (w_rd.expiry < r_item.expiry) begin
                    n_best_pos = w_lc[IDX_W-1:0];
                    n_best     = w_rd;
                end else begin
                    n_best_pos = r_pos;
                    n_best     = r_item;
                end
            end
            // right child against the best so far, then move one level
            tmhq_pkg::ST_SD_RIGHT: begin
                w_wr.en   = 1'b1;
                w_wr.addr = r_pos;
                if (w_tgt_pos == r_pos) begin
                    w_wr.data = r_item;
                end else begin
                    w_wr.data = w_tgt;
                    n_pos     = w_tgt_pos;
                end
            end
            tmhq_pkg::ST_RESULT: begin
                if (w_out_free) begin
                    w_push      = 1'b1;
                    w_push_item = r_res;
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tmhq_pkg::ST_IDLE;
            r_count      <= '0;
            r_last_ident <= '0;
            r_pend_valid <= 1'b0;
            r_nfire      <= '0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_last_ident <= n_last_ident;
            r_pend_valid <= n_pend_valid;
            r_nfire      <= n_nfire;
        end
    end

    // working payload
    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_best_pos  <= n_best_pos;
        r_idx       <= n_idx;
        r_item      <= n_item;
        r_best      <= n_best;
        r_now       <= n_now;
        r_cancel_id <= n_cancel_id;
        r_pend_id   <= n_pend_id;
        r_res       <= n_res;
    end

endmodule

`default_nettype wire
